// File: sv/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for the priority scheduler
// Payload structs, status and op codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned OCC_W = 5;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_REJECTED = 3'd1,
    ST_IDLE     = 3'd2,
    ST_RAN      = 3'd3,
    ST_DONE     = 3'd4
  } status_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  proc_id;
    logic [7:0]  prio;
    logic [31:0] arrive_tick;
    logic [15:0] service_ticks;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       running_id;
    logic [31:0]      tick_time;
    logic [31:0]      turnaround;
    logic [OCC_W-1:0] occupancy;
  } out_t;

  // one process table entry
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [31:0] arrival;
    logic [15:0] remaining;
  } rec_t;

  typedef struct packed {
    logic latch;
    logic scan_start;
    logic scan_step;
    logic do_add;
    logic do_run;
  } pps_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic scan_done;
    logic out_free;
  } pps_stat_t;

endpackage

// File: sv/preemptive_priority_scheduler.sv
// Sequence: an add result is loaded from the add state once the output register
//   is free; a tick result after a one-entry-per-cycle scan of all slots,
//   read return, select, then run, which also waits for a free output register.
// Throughput: one request at a time, next accept the cycle after the result
//   loads; a held result stalls the load and so the next accept.
// Reset (rst_ni low, async): table empty, tick and occupancy zero, no result.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: process table with priority selection
// Adds processes into free slots; each tick runs the best arrived process.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  // request channel
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_req_i,
  // result channel
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_rsp_o
);

  // Controller and datapath talk only through these two bundles.
  pps_cmd_t  cmd;
  pps_stat_t stat;

  // Sequencer: idle -> add -> idle, or idle -> scan -> run -> idle.
  // Add and run both wait for a free output register before touching state,
  // so a stalled result is never overwritten; it holds back the next bookkeeping.
  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: table memory (one write, one registered read port), valid
  // bits, free-slot encoder, scan comparator, tick/occupancy counters and
  // the result register that separates the two channels.
  // Scan walks slots in ascending order and keeps strictly greater
  // priorities only, so ties resolve to the lowest slot.
  pps_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: sv/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl: scheduler sequencer
// Accepts one request at a time and steps the datapath through add or scan/run.
// ----------------------------------------------------------------------------
module pps_ctrl
  import pps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pps_stat_t stat_i,
  output pps_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_RUN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          if (stat_i.in_tick) begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end else begin
            state_d = S_ADD;
          end
        end
      end
      S_ADD: begin
        if (stat_i.out_free) begin
          cmd_o.do_add = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (stat_i.out_free) begin
          cmd_o.do_run = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath: process table, priority scan and result register
// Table in a single-port-write memory; valid bits and counters in flops.
// ----------------------------------------------------------------------------
module pps_datapath
  import pps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_t       in_req_i,
  input  pps_cmd_t  cmd_i,
  output pps_stat_t stat_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_t      out_rsp_o
);

  rec_t             mem_q [SLOTS];
  rec_t             rd_data_q;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [31:0]      tick_q, tick_d;
  logic [CNT_W-1:0] used_q, used_d;
  in_t              item_q;

  logic [CNT_W-1:0] issue_q, issue_d;
  logic             rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             rd_en;
  logic             found_q, found_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  rec_t             best_q, best_d;

  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_data;

  logic [IDX_W-1:0] free_idx;
  logic             full;
  logic [15:0]      rem_next;
  logic             hit;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign full     = &valid_q;
  assign rem_next = best_q.remaining - 16'd1;
  assign rd_en    = cmd_i.scan_step && (issue_q != CNT_W'(SLOTS));

  // candidate on the read data returning this cycle
  assign hit = rd_pend_q && valid_q[rd_idx_q] && (rd_data_q.arrival <= tick_q)
               && (!found_q || (rd_data_q.prio > best_q.prio));

  assign stat_o.in_tick   = (in_req_i.op == OP_TICK);
  assign stat_o.scan_done = (issue_q == CNT_W'(SLOTS)) && !rd_pend_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    valid_d     = valid_q;
    tick_d      = tick_q;
    used_d      = used_q;
    issue_d     = issue_q;
    rd_pend_d   = 1'b0;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = free_idx;
    wr_data     = '0;

    if (cmd_i.scan_start) begin
      issue_d = '0;
      found_d = 1'b0;
    end

    if (cmd_i.scan_step) begin
      if (rd_en) begin
        rd_idx_d  = issue_q[IDX_W-1:0];
        rd_pend_d = 1'b1;
        issue_d   = issue_q + CNT_W'(1);
      end
      if (hit) begin
        found_d    = 1'b1;
        best_idx_d = rd_idx_q;
        best_d     = rd_data_q;
      end
    end

    if (cmd_i.do_add) begin
      out_valid_d          = 1'b1;
      out_d.running_id     = '0;
      out_d.tick_time      = tick_q;
      out_d.turnaround     = '0;
      if (full) begin
        out_d.status    = ST_REJECTED;
        out_d.occupancy = OCC_W'(used_q);
      end else begin
        wr_en             = 1'b1;
        wr_addr           = free_idx;
        wr_data.id        = item_q.proc_id;
        wr_data.prio      = item_q.prio;
        wr_data.arrival   = item_q.arrive_tick;
        wr_data.remaining = (item_q.service_ticks == 16'd0) ? 16'd1
                                                            : item_q.service_ticks;
        valid_d[free_idx] = 1'b1;
        used_d            = used_q + CNT_W'(1);
        out_d.status      = ST_ADDED;
        out_d.occupancy   = OCC_W'(used_d);
      end
    end

    if (cmd_i.do_run) begin
      out_valid_d      = 1'b1;
      tick_d           = tick_q + 32'd1;
      out_d.tick_time  = tick_q;
      out_d.running_id = '0;
      out_d.turnaround = '0;
      out_d.status     = ST_IDLE;
      if (found_q) begin
        out_d.running_id = best_q.id;
        if (rem_next == 16'd0) begin
          valid_d[best_idx_q] = 1'b0;
          if (used_q != '0) begin
            used_d = used_q - CNT_W'(1);
          end
          out_d.status     = ST_DONE;
          out_d.turnaround = tick_q + 32'd1 - best_q.arrival;
        end else begin
          wr_en             = 1'b1;
          wr_addr           = best_idx_q;
          wr_data           = best_q;
          wr_data.remaining = rem_next;
          out_d.status      = ST_RAN;
        end
      end
      out_d.occupancy = OCC_W'(used_d);
    end
  end

  // process table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[issue_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      tick_q      <= '0;
      used_q      <= '0;
      issue_q     <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      tick_q      <= tick_d;
      used_q      <= used_d;
      issue_q     <= issue_d;
      rd_pend_q   <= rd_pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_req_i;
    end
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  a_used_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == CNT_W'($countones(valid_q)))
    else $error("occupancy count out of step with valid bits");

  a_load_needs_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_add || cmd_i.do_run) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while occupied");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_run |=> (tick_q == $past(tick_q) + 32'd1))
    else $error("tick did not advance on run");

  a_best_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && cmd_i.do_run) |-> valid_q[best_idx_q])
    else $error("selected slot is not in use");
`endif

endmodule
